/* src/ricker_wavelet_sample_defines.svh */
// Assertion macros for the Ricker wavelet sample RTL, used by the pipeline control.
`ifndef RICKER_WAVELET_SAMPLE_DEFINES_SVH
`define RICKER_WAVELET_SAMPLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RWV_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rwv same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RWV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rwv next-cycle check failed");

`endif

/* src/rwv_pkg.sv */
// Package: types, constants and the exponential table for the wavelet pipeline.
`default_nettype none

package rwv_pkg;

   localparam int unsigned NUM_STAGES = 11;

   localparam int unsigned TIME_STEP_WIDTH = 32;
   localparam int unsigned PEAK_FREQ_WIDTH = 16;
   localparam int unsigned INDEX_WIDTH     = 16;
   localparam int unsigned AMP_WIDTH       = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TIME_STEP      = 1'b0,
      CSR_PEAK_FREQUENCY = 1'b1
   } csr_index_type;

   localparam logic [TIME_STEP_WIDTH-1:0] TIME_STEP_RESET      = 32'd2147484;
   localparam logic [PEAK_FREQ_WIDTH-1:0] PEAK_FREQUENCY_RESET = 16'd7680;

   // Time in periods is scaled by 2^40.
   localparam logic [63:0] ONE_PERIOD  = 64'h0000_0100_0000_0000;
   localparam logic [63:0] TWO_PERIODS = 64'h0000_0200_0000_0000;

   // pi^2 in Q.30, split into integer part and fraction.
   localparam logic [33:0] PI2_Q30  = 34'd10597407032;
   localparam logic [3:0]  PI2_INT  = PI2_Q30[33:30];
   localparam logic [29:0] PI2_FRAC = PI2_Q30[29:0];

   localparam logic [14:0] AMP_LIMIT = 15'd16384;

   // exp(-pi^2*k/256) in Q.32, built by repeated rounded multiplication.
   localparam int unsigned EXP_SEGS = 256;
   localparam logic [31:0] EXP_RATIO = 32'd4132534085;

   typedef logic [EXP_SEGS:0][32:0] exp_rom_type;

   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] acc;
      rom[0] = 33'h1_0000_0000;
      for (int k = 1; k <= int'(EXP_SEGS); k++) begin
         acc    = 64'(rom[k-1]) * 64'(EXP_RATIO) + 64'h0000_0000_8000_0000;
         rom[k] = {1'b0, acc[63:32]};
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

/* src/rwv_pipe_ctl.sv */
// Pipeline control: per-stage valid bits, ready chain and load enables.
`default_nettype none
`include "ricker_wavelet_sample_defines.svh"

module rwv_pipe_ctl
   import rwv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [NUM_STAGES-1:0] stage_load
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_ready;
   logic [NUM_STAGES-1:0] src_valid;

   // A stage takes a new request when it is empty or its contents move on.
   always_comb begin
      stage_ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
   end

   assign src_valid  = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign stage_load = stage_ready & src_valid;
   assign valid_in   = (stage_ready & src_valid) | (~stage_ready & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // Requests in flight change only by what enters and what leaves.
   `RWV_ASSERT_NEXT(a_occupancy, clock, reset, 1'b1, $countones(valid_ff) == $past($countones(valid_ff)) + int'($past(req_valid && req_ready)) - int'($past(rsp_valid && rsp_ready)))
   // A stalled stage keeps its request.
   `RWV_ASSERT_NEXT(a_stall_keeps, clock, reset, 1'b1, ($past(valid_ff & ~stage_ready) & ~valid_ff) == '0)
   // A full pipeline with a stalled output refuses new requests.
   `RWV_ASSERT_IMPL(a_full_backpressure, clock, reset, (&valid_ff) && !rsp_ready, !req_ready)

endmodule

`default_nettype wire

/* src/rwv_phase.sv */
// Phase stages: time in periods and its rounded distance from one period.
`default_nettype none

module rwv_phase
   import rwv_pkg::*;
(
   input  logic                       clock,
   input  logic [2:0]                 load,
   input  logic [INDEX_WIDTH-1:0]     sample_index,
   input  logic                       in_range,
   input  logic [TIME_STEP_WIDTH-1:0] time_step,
   input  logic [PEAK_FREQ_WIDTH-1:0] peak_frequency,
   output logic [30:0]                delta,
   output logic                       zero
);

   logic [47:0] s1_prod_ff;
   logic [47:0] s1_prod_in;
   logic        s1_zero_ff;
   logic [63:0] s2_u_ff;
   logic [63:0] s2_u_in;
   logic        s2_zero_ff;
   logic [30:0] s3_dist_ff;
   logic [30:0] s3_dist_in;
   logic        s3_zero_ff;
   logic        s3_zero_in;
   logic [63:0] abs_diff;
   logic [63:0] rounded;

   assign s1_prod_in = 48'(sample_index) * 48'(time_step);
   assign s2_u_in    = 64'(s1_prod_ff) * 64'(peak_frequency);

   // Beyond two periods the sample is zero; exactly two is still evaluated.
   assign abs_diff   = (s2_u_ff >= ONE_PERIOD) ? (s2_u_ff - ONE_PERIOD)
                                               : (ONE_PERIOD - s2_u_ff);
   assign rounded    = abs_diff + 64'd512;
   assign s3_dist_in = rounded[40:10];
   assign s3_zero_in = s2_zero_ff || (s2_u_ff > TWO_PERIODS);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_prod_ff <= s1_prod_in;
         s1_zero_ff <= !in_range;
      end
      if (load[1]) begin
         s2_u_ff    <= s2_u_in;
         s2_zero_ff <= s1_zero_ff;
      end
      if (load[2]) begin
         s3_dist_ff <= s3_dist_in;
         s3_zero_ff <= s3_zero_in;
      end
   end

   assign delta = s3_dist_ff;
   assign zero  = s3_zero_ff;

endmodule

`default_nettype wire

/* src/rwv_exp_eval.sv */
// Exponential stages: square, table interpolation and the polynomial factor.
`default_nettype none

module rwv_exp_eval
   import rwv_pkg::*;
(
   input  logic        clock,
   input  logic [5:0]  load,
   input  logic [30:0] delta,
   input  logic        zero_in,
   output logic [16:0] exp_q16,
   output logic        poly_neg,
   output logic [34:0] poly_mag,
   output logic        zero_out
);

   // stage 4: square
   logic [61:0] s4_sq_ff;
   logic [61:0] s4_sq_in;
   logic        s4_zero_ff;
   // stage 5: round to Q.30
   logic [61:0] sq_rnd;
   logic [30:0] s5_d2_ff;
   logic [30:0] s5_d2_in;
   logic        s5_zero_ff;
   // stage 6: table read and pi^2 fraction product
   logic [8:0]  seg;
   logic [8:0]  seg_next;
   logic [32:0] s6_ek_ff;
   logic [32:0] s6_ek1_ff;
   logic [21:0] s6_frac_ff;
   logic [60:0] s6_m_ff;
   logic [60:0] s6_m_in;
   logic [30:0] s6_d2_ff;
   logic        s6_zero_ff;
   // stage 7: segment slope and xx
   logic [60:0] m_rnd;
   logic [32:0] ek_diff;
   logic [27:0] s7_diff_ff;
   logic [34:0] s7_xx_ff;
   logic [34:0] s7_xx_in;
   logic [32:0] s7_ek_ff;
   logic [21:0] s7_frac_ff;
   logic        s7_zero_ff;
   // stage 8: interpolation product and 1 - 2*xx
   logic [49:0] s8_prod_ff;
   logic [49:0] s8_prod_in;
   logic [32:0] s8_ek_ff;
   logic [35:0] twice_xx;
   logic        s8_neg_ff;
   logic        s8_neg_in;
   logic [34:0] s8_mag_ff;
   logic [34:0] s8_mag_in;
   logic        s8_zero_ff;
   // stage 9: interpolated exponential in Q.16
   logic [50:0] prod_rnd;
   logic [32:0] e_q32;
   logic [33:0] e_rnd;
   logic [16:0] s9_e16_ff;
   logic [16:0] s9_e16_in;
   logic        s9_neg_ff;
   logic [34:0] s9_mag_ff;
   logic        s9_zero_ff;

   assign s4_sq_in = 62'(delta) * 62'(delta);

   assign sq_rnd   = s4_sq_ff + 62'h2000_0000;
   assign s5_d2_in = sq_rnd[60:30];

   // The last segment is only reached with a zero fraction: clamp its upper index.
   assign seg      = s5_d2_ff[30:22];
   assign seg_next = (seg == 9'(EXP_SEGS)) ? seg : seg + 9'd1;
   assign s6_m_in  = 61'(s5_d2_ff) * 61'(PI2_FRAC);

   assign ek_diff  = s6_ek_ff - s6_ek1_ff;
   assign m_rnd    = s6_m_ff + 61'h2000_0000;
   assign s7_xx_in = 35'(s6_d2_ff) * 35'(PI2_INT) + 35'(m_rnd[60:30]);

   assign s8_prod_in = 50'(s7_diff_ff) * 50'(s7_frac_ff);
   assign twice_xx   = {1'b0, s7_xx_ff} << 1;
   assign s8_neg_in  = twice_xx > 36'h0_4000_0000;
   assign s8_mag_in  = s8_neg_in ? 35'(twice_xx - 36'h0_4000_0000)
                                 : 35'(36'h0_4000_0000 - twice_xx);

   assign prod_rnd  = 51'(s8_prod_ff) + 51'h20_0000;
   assign e_q32     = s8_ek_ff - 33'(prod_rnd[50:22]);
   assign e_rnd     = 34'(e_q32) + 34'h8000;
   assign s9_e16_in = e_rnd[32:16];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s4_sq_ff   <= s4_sq_in;
         s4_zero_ff <= zero_in;
      end
      if (load[1]) begin
         s5_d2_ff   <= s5_d2_in;
         s5_zero_ff <= s4_zero_ff;
      end
      if (load[2]) begin
         s6_ek_ff   <= EXP_ROM[seg];
         s6_ek1_ff  <= EXP_ROM[seg_next];
         s6_frac_ff <= s5_d2_ff[21:0];
         s6_m_ff    <= s6_m_in;
         s6_d2_ff   <= s5_d2_ff;
         s6_zero_ff <= s5_zero_ff;
      end
      if (load[3]) begin
         s7_diff_ff <= ek_diff[27:0];
         s7_xx_ff   <= s7_xx_in;
         s7_ek_ff   <= s6_ek_ff;
         s7_frac_ff <= s6_frac_ff;
         s7_zero_ff <= s6_zero_ff;
      end
      if (load[4]) begin
         s8_prod_ff <= s8_prod_in;
         s8_ek_ff   <= s7_ek_ff;
         s8_neg_ff  <= s8_neg_in;
         s8_mag_ff  <= s8_mag_in;
         s8_zero_ff <= s7_zero_ff;
      end
      if (load[5]) begin
         s9_e16_ff  <= s9_e16_in;
         s9_neg_ff  <= s8_neg_ff;
         s9_mag_ff  <= s8_mag_ff;
         s9_zero_ff <= s8_zero_ff;
      end
   end

   assign exp_q16  = s9_e16_ff;
   assign poly_neg = s9_neg_ff;
   assign poly_mag = s9_mag_ff;
   assign zero_out = s9_zero_ff;

endmodule

`default_nettype wire

/* src/rwv_amp_scale.sv */
// Output stages: product of both factors, rounding, saturation and sign.
`default_nettype none

module rwv_amp_scale
   import rwv_pkg::*;
(
   input  logic                        clock,
   input  logic [1:0]                  load,
   input  logic [16:0]                 exp_q16,
   input  logic                        poly_neg,
   input  logic [34:0]                 poly_mag,
   input  logic                        zero,
   output logic signed [AMP_WIDTH-1:0] amplitude
);

   logic [51:0]                 s10_mag_ff;
   logic [51:0]                 s10_mag_in;
   logic                        s10_neg_ff;
   logic                        s10_zero_ff;
   logic [52:0]                 mag_rnd;
   logic [20:0]                 mag_q14;
   logic [14:0]                 mag_sat;
   logic signed [AMP_WIDTH-1:0] s11_amp_ff;
   logic signed [AMP_WIDTH-1:0] s11_amp_in;

   assign s10_mag_in = 52'(exp_q16) * 52'(poly_mag);

   // Round half away from zero on the magnitude, then clamp to +-1.0.
   assign mag_rnd = 53'(s10_mag_ff) + 53'h0_0000_8000_0000;
   assign mag_q14 = mag_rnd[52:32];
   assign mag_sat = (mag_q14 > 21'(AMP_LIMIT)) ? AMP_LIMIT : mag_q14[14:0];

   always_comb begin
      if (s10_zero_ff) begin
         s11_amp_in = '0;
      end else if (s10_neg_ff) begin
         s11_amp_in = -$signed(AMP_WIDTH'(mag_sat));
      end else begin
         s11_amp_in = $signed(AMP_WIDTH'(mag_sat));
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s10_mag_ff  <= s10_mag_in;
         s10_neg_ff  <= poly_neg;
         s10_zero_ff <= zero;
      end
      if (load[1]) begin
         s11_amp_ff <= s11_amp_in;
      end
   end

   assign amplitude = s11_amp_ff;

endmodule

`default_nettype wire

/* src/ricker_wavelet_sample.sv */
// Ricker wavelet sample generator: 11-stage pipeline, one request per cycle unless the output stalls.
// An accepted request passes through the stage registers s1 to s11 in order before its response shows on rsp_valid.
// Throughput: one request per cycle; the stall of a full pipeline reaches req_ready.
// The output register holds a waiting response while earlier stages keep filling.
// Reset clears all stage valid bits and loads the time-step and peak-frequency registers with their defaults.
`default_nettype none

module ricker_wavelet_sample
   import rwv_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [INDEX_WIDTH-1:0]      req_sample_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [AMP_WIDTH-1:0] rsp_amplitude,
   input  logic                        csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic [TIME_STEP_WIDTH-1:0] time_step_ff;
   logic [TIME_STEP_WIDTH-1:0] time_step_in;
   logic [PEAK_FREQ_WIDTH-1:0] peak_frequency_ff;
   logic [PEAK_FREQ_WIDTH-1:0] peak_frequency_in;
   logic [NUM_STAGES-1:0]      stage_load;
   logic                       in_range;
   logic [30:0]                delta;
   logic                       phase_zero;
   logic [16:0]                exp_q16;
   logic                       poly_neg;
   logic [34:0]                poly_mag;
   logic                       exp_zero;

   always_comb begin
      time_step_in      = time_step_ff;
      peak_frequency_in = peak_frequency_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TIME_STEP:      time_step_in      = csr_wdata[TIME_STEP_WIDTH-1:0];
            CSR_PEAK_FREQUENCY: peak_frequency_in = csr_wdata[PEAK_FREQ_WIDTH-1:0];
            default: begin
               time_step_in      = time_step_ff;
               peak_frequency_in = peak_frequency_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff      <= TIME_STEP_RESET;
         peak_frequency_ff <= PEAK_FREQUENCY_RESET;
      end else begin
         time_step_ff      <= time_step_in;
         peak_frequency_ff <= peak_frequency_in;
      end
   end

   // Indexes past the sample count give a zero response.
   assign in_range = 32'(req_sample_index) < MAX_SAMPLES;

   rwv_pipe_ctl u_pipe_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stage_load (stage_load)
   );

   rwv_phase u_phase (
      .clock          (clock),
      .load           (stage_load[2:0]),
      .sample_index   (req_sample_index),
      .in_range       (in_range),
      .time_step      (time_step_ff),
      .peak_frequency (peak_frequency_ff),
      .delta          (delta),
      .zero           (phase_zero)
   );

   rwv_exp_eval u_exp_eval (
      .clock    (clock),
      .load     (stage_load[8:3]),
      .delta    (delta),
      .zero_in  (phase_zero),
      .exp_q16  (exp_q16),
      .poly_neg (poly_neg),
      .poly_mag (poly_mag),
      .zero_out (exp_zero)
   );

   rwv_amp_scale u_amp_scale (
      .clock     (clock),
      .load      (stage_load[10:9]),
      .exp_q16   (exp_q16),
      .poly_neg  (poly_neg),
      .poly_mag  (poly_mag),
      .zero      (exp_zero),
      .amplitude (rsp_amplitude)
   );

endmodule

`default_nettype wire
